[hdl/bdhd_pkg.sv]
// ----------------------------------------------------------------------------
// bdhd_pkg
// Types, constants and register codes shared by the button debounce and hold
// detection block.
// ----------------------------------------------------------------------------
package bdhd_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int MAX_BUTTONS = 4;

   localparam int TIME_W = 32;
   localparam int MS_W   = 16;

   localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [MS_W-1:0] HOLD_RESET     = 16'd1000;
   localparam logic            PRESSED_RESET  = 1'b0;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = MS_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_MS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSED_LEVEL = 2'd2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 144;

   typedef struct packed {
      logic [MS_W-1:0] debounce_ms;
      logic [MS_W-1:0] hold_ms;
      logic            pressed_level;
   } cfg_type;

   typedef struct packed {
      logic              pressed;
      logic              released;
      logic              down;
      logic              hold;
      logic [TIME_W-1:0] held_time;
   } lane_out_type;

endpackage

[hdl/button_debounce_hold_detect.sv]
// ----------------------------------------------------------------------------
// button_debounce_hold_detect
// Each poll's result is registered in the output register, or in the skid
// register while the output one holds a result that waits to be taken.
// One poll per cycle while the skid register is empty; all button lanes
// update in the same cycle. Reset is synchronous and active high: registers
// return to their reset values and all buttons start stably released.
// ----------------------------------------------------------------------------
module button_debounce_hold_detect (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // now_ms [31:0], raw_levels [35:32], zero fill [39:36]
   input  logic [bdhd_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pressed_pulses [3:0], released_pulses [7:4], down_flags [11:8],
   // hold_pulses [15:12], held_time_0 [47:16], held_time_1 [79:48],
   // held_time_2 [111:80], held_time_3 [143:112]
   output logic [bdhd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdhd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bdhd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bdhd_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              take;
   logic              in_ready;
   logic [TIME_W-1:0] now_ms;
   logic [MAX_BUTTONS-1:0] raw_levels;
   lane_out_type      lanes [MAX_BUTTONS];

   assign csr_ready  = 1'b1;
   assign req_tready = in_ready;
   assign take       = req_tvalid && in_ready;
   assign now_ms     = req_tdata[TIME_W-1:0];
   assign raw_levels = req_tdata[TIME_W +: MAX_BUTTONS];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:   cfg_in.debounce_ms   = csr_data;
            CSR_HOLD_MS:       cfg_in.hold_ms       = csr_data;
            CSR_PRESSED_LEVEL: cfg_in.pressed_level = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.hold_ms       <= HOLD_RESET;
         cfg_ff.pressed_level <= PRESSED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_lane
      if (i < NUM_BUTTONS) begin : g_used
         bdhd_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .take   (take),
            .cfg    (cfg_ff),
            .now_ms (now_ms),
            .raw    (raw_levels[i]),
            .result (lanes[i])
         );
      end else begin : g_unused
         assign lanes[i] = '0;
      end
   end

   bdhd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .lanes      (lanes),
      .in_ready   (in_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hdl/bdhd_lane.sv]
// ----------------------------------------------------------------------------
// bdhd_lane
// Debounce and hold tracking for one button, updated on every poll transfer.
// ----------------------------------------------------------------------------
module bdhd_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  bdhd_pkg::cfg_type        cfg,
   input  logic [bdhd_pkg::TIME_W-1:0] now_ms,
   input  logic                     raw,
   output bdhd_pkg::lane_out_type   result
);
   import bdhd_pkg::*;

   logic              last_raw_ff, last_raw_in;
   logic [TIME_W-1:0] change_stamp_ff, change_stamp_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic              hold_running_ff, hold_running_in;
   logic              hold_fired_ff, hold_fired_in;

   logic [TIME_W-1:0] steady_time;
   logic [TIME_W-1:0] start;
   logic [TIME_W-1:0] elapsed;
   logic              flip;
   logic              is_down;
   logic              hold_hit;

   always_comb begin
      last_raw_in     = raw;
      change_stamp_in = (raw != last_raw_ff) ? now_ms : change_stamp_ff;
      steady_time     = now_ms - change_stamp_in;
      flip            = (steady_time > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms})
                        && (raw != stable_ff);
      stable_in       = flip ? raw : stable_ff;
      is_down         = (stable_in == cfg.pressed_level);
      start           = hold_running_ff ? hold_start_ff : now_ms;
      elapsed         = now_ms - start;
      hold_hit        = is_down && !hold_fired_ff
                        && (elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.hold_ms});
      hold_running_in = is_down;
      hold_fired_in   = is_down && (hold_fired_ff || hold_hit);
      hold_start_in   = is_down ? start : '0;

      result.pressed   = flip && (raw == cfg.pressed_level);
      result.released  = flip && (raw != cfg.pressed_level);
      result.down      = is_down;
      result.hold      = hold_hit;
      result.held_time = is_down ? elapsed : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= ~PRESSED_RESET;
         change_stamp_ff <= '0;
         stable_ff       <= ~PRESSED_RESET;
         hold_start_ff   <= '0;
         hold_running_ff <= 1'b0;
         hold_fired_ff   <= 1'b0;
      end else if (take) begin
         last_raw_ff     <= last_raw_in;
         change_stamp_ff <= change_stamp_in;
         stable_ff       <= stable_in;
         hold_start_ff   <= hold_start_in;
         hold_running_ff <= hold_running_in;
         hold_fired_ff   <= hold_fired_in;
      end
   end

endmodule

[hdl/bdhd_merge.sv]
// ----------------------------------------------------------------------------
// bdhd_merge
// Packs the lane results into one result word and holds it in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
module bdhd_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  bdhd_pkg::lane_out_type                lanes [bdhd_pkg::MAX_BUTTONS],
   output logic                                  in_ready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bdhd_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import bdhd_pkg::*;

   logic [RSP_DATA_W-1:0] merged;
   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [RSP_DATA_W-1:0] skid_data_ff, skid_data_in;
   logic                  pop;

   always_comb begin
      merged = '0;
      for (int i = 0; i < MAX_BUTTONS; i++) begin
         merged[i]                       = lanes[i].pressed;
         merged[MAX_BUTTONS + i]         = lanes[i].released;
         merged[2*MAX_BUTTONS + i]       = lanes[i].down;
         merged[3*MAX_BUTTONS + i]       = lanes[i].hold;
         merged[4*MAX_BUTTONS + i*TIME_W +: TIME_W] = lanes[i].held_time;
      end
   end

   assign pop      = out_valid_ff && rsp_tready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!out_valid_in) begin
            out_data_in  = merged;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = merged;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[hdl/bdhd_checker.sv]
// ----------------------------------------------------------------------------
// bdhd_checker
// Port-level checks on the result stream of the debounce and hold block.
// ----------------------------------------------------------------------------
module bdhd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bdhd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bdhd_pkg::*;

   logic [3:0] pressed;
   logic [3:0] released;
   logic [3:0] down;
   logic [3:0] hold;

   assign pressed  = rsp_tdata[3:0];
   assign released = rsp_tdata[7:4];
   assign down     = rsp_tdata[11:8];
   assign hold     = rsp_tdata[15:12];

   a_pulse_vs_down: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (((pressed | hold) & ~down) == 4'd0) && ((released & down) == 4'd0))
      else $error("pressed, hold or released pulse disagrees with down flags");

   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !down[0] |-> rsp_tdata[47:16] == 32'd0)
      else $error("held time of a released button is not zero");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed before its transfer");

endmodule

bind button_debounce_hold_detect bdhd_checker u_bdhd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
